>>> rtl/axis_angle_vector_rotate_core_macros.svh
// assertion macros for the axis-angle rotation core checker
// no dependencies; included by the checker file only
`ifndef AXIS_ANGLE_VECTOR_ROTATE_CORE_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define AAVR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aavr check failed");

// next-cycle implication, disabled during reset
`define AAVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aavr check failed");

// next-cycle implication that also holds through reset
`define AAVR_ASSERT_NEXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("aavr check failed");

`endif

>>> rtl/aavr_pkg.sv
// shared constants, types and rounding helper for the axis-angle rotation core
// no dependencies
package aavr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int BK_STAGES    = 1 + SQRT_STEPS + DIV_STEPS;
    localparam int MATH_STAGES  = 7;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam logic [33:0] GAIN_Q30 = 34'd652032874;

    localparam logic [31:0] ATAN_TURNS [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0][31:0] v;
        logic [2:0][31:0] m;
        logic [2:0][63:0] sq;
        logic [2:0]       neg;
        logic             zero;
        logic             flip;
        logic [32:0]      z;
    } fr_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        fr_t  item;
    } fq_t;

    // round half up at bit 30, floor shift
    function automatic logic signed [79:0] rnd30(input logic signed [79:0] p);
        logic signed [79:0] t;
        t = p + 80'sd536870912;
        return t >>> 30;
    endfunction

endpackage

>>> rtl/aavr_fifo.sv
// four-entry queue between front and back of the rotation core
// depends on aavr_pkg
module aavr_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  aavr_pkg::fr_t   push_item,
    output logic            full,
    input  logic            pop,
    output aavr_pkg::fq_t   head
);
    aavr_pkg::fr_t mem [aavr_pkg::FIFO_DEPTH];
    logic [aavr_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [aavr_pkg::FIFO_AW:0]   count_reg;
    logic do_push, do_pop;

    assign full       = (count_reg == (aavr_pkg::FIFO_AW+1)'(aavr_pkg::FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end
endmodule

>>> rtl/aavr_front.sv
// front end: accepts requests, takes axis magnitudes and squares, folds the angle
// depends on aavr_pkg
module aavr_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [207:0]   in_data,
    output logic           push,
    output aavr_pkg::fr_t  push_item,
    input  logic           q_full
);
    logic          f_valid_reg, f_valid_next;
    aavr_pkg::fr_t f_item_reg, f_item_next;
    logic          take;
    logic [31:0]   phase;

    assign in_ready  = !f_valid_reg || !q_full;
    assign take      = in_valid && in_ready;
    assign push      = f_valid_reg;
    assign push_item = f_item_reg;

    always_comb begin
        f_valid_next = take ? 1'b1 : (f_valid_reg && q_full);
        for (int k = 0; k < 3; k++) begin
            f_item_next.v[k]   = in_data[32*k +: 32];
            f_item_next.neg[k] = in_data[96 + 32*k + 31];
            f_item_next.m[k]   = f_item_next.neg[k] ? 32'(-in_data[96 + 32*k +: 32])
                                                    : in_data[96 + 32*k +: 32];
            f_item_next.sq[k]  = 64'(f_item_next.m[k]) * 64'(f_item_next.m[k]);
        end
        f_item_next.zero = (in_data[191:96] == '0);
        // second and third quadrant move by half a turn
        f_item_next.flip = in_data[207] ^ in_data[206];
        phase            = {in_data[207:192], 16'h0000};
        phase[31]        = phase[31] ^ f_item_next.flip;
        f_item_next.z    = {phase[31], phase};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_item_reg <= f_item_next;
        end
    end
endmodule

>>> rtl/aavr_back.sv
// back end: square root, unit axis division, cordic sine and cosine, rotation maths
// depends on aavr_pkg
module aavr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  aavr_pkg::fq_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [95:0]   out_data,
    output logic [1:0]    out_flags
);
    typedef struct packed {
        logic [2:0][31:0] v;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
        logic             zero;
        logic             flip;
        logic [33:0]      cx;
        logic [33:0]      cy;
        logic [32:0]      cz;
        logic [63:0]      n;
        logic [33:0]      srem;
        logic [31:0]      root;
        logic [2:0][61:0] num;
        logic [2:0][31:0] drem;
        logic [2:0][30:0] q;
    } bk_t;

    localparam int NS = aavr_pkg::BK_STAGES;
    localparam int NM = aavr_pkg::MATH_STAGES;

    logic ce;
    bk_t  stg_reg  [NS];
    bk_t  stg_next [NS];
    logic vld_reg  [NS];
    logic mvld_reg [NM];

    // whole pipeline moves together whenever the output slot can take a result
    assign ce        = !mvld_reg[NM-1] || out_ready;
    assign pop       = ce;
    assign out_valid = mvld_reg[NM-1];

    always_comb begin
        stg_next[0]      = '0;
        for (int k = 0; k < 3; k++) begin
            stg_next[0].v[k]   = head.item.v[k];
            stg_next[0].m[k]   = head.item.m[k];
            stg_next[0].neg[k] = head.item.neg[k];
        end
        stg_next[0].zero = head.item.zero;
        stg_next[0].flip = head.item.flip;
        stg_next[0].cx   = aavr_pkg::GAIN_Q30;
        stg_next[0].cy   = '0;
        stg_next[0].cz   = head.item.z;
        stg_next[0].n    = head.item.sq[0] + head.item.sq[1] + head.item.sq[2];
    end

    for (genvar j = 1; j < NS; j++) begin : g_stg
        if (j <= aavr_pkg::SQRT_STEPS) begin : g_sqrt
            always_comb begin
                bk_t s;
                logic [35:0] t;
                logic [35:0] trial;
                logic signed [33:0] xs;
                logic signed [33:0] ys;
                s     = stg_reg[j-1];
                t     = {s.srem, s.n[63:62]};
                trial = {2'b00, s.root, 2'b01};
                s.n   = {s.n[61:0], 2'b00};
                if (t >= trial) begin
                    s.srem = 34'(t - trial);
                    s.root = {s.root[30:0], 1'b1};
                end else begin
                    s.srem = t[33:0];
                    s.root = {s.root[30:0], 1'b0};
                end
                xs = $signed(s.cx) >>> (j-1);
                ys = $signed(s.cy) >>> (j-1);
                if ((j-1) < aavr_pkg::NSTEPS) begin
                    if (!s.cz[32]) begin
                        s.cx = 34'($signed(s.cx) - ys);
                        s.cy = 34'($signed(s.cy) + xs);
                        s.cz = s.cz - {1'b0, aavr_pkg::ATAN_TURNS[(j-1) % aavr_pkg::TAB_LEN]};
                    end else begin
                        s.cx = 34'($signed(s.cx) + ys);
                        s.cy = 34'($signed(s.cy) - xs);
                        s.cz = s.cz + {1'b0, aavr_pkg::ATAN_TURNS[(j-1) % aavr_pkg::TAB_LEN]};
                    end
                end
                stg_next[j] = s;
            end
        end else begin : g_div
            always_comb begin
                bk_t s;
                logic [32:0] r;
                s = stg_reg[j-1];
                if (j == aavr_pkg::SQRT_STEPS + 1) begin
                    for (int k = 0; k < 3; k++) begin
                        s.num[k]  = {s.m[k], 30'd0} + 62'(s.root[31:1]);
                        s.drem[k] = {1'b0, s.num[k][61:31]};
                        s.q[k]    = '0;
                    end
                end
                for (int k = 0; k < 3; k++) begin
                    r = {s.drem[k], s.num[k][30 - (j - aavr_pkg::SQRT_STEPS - 1)]};
                    if (r >= {1'b0, s.root}) begin
                        s.drem[k] = 32'(r - {1'b0, s.root});
                        s.q[k]    = {s.q[k][29:0], 1'b1};
                    end else begin
                        s.drem[k] = r[31:0];
                        s.q[k]    = {s.q[k][29:0], 1'b0};
                    end
                end
                stg_next[j] = s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) vld_reg[i] <= 1'b0;
            for (int i = 0; i < NM; i++) mvld_reg[i] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= head.valid;
            for (int i = 1; i < NS; i++) vld_reg[i] <= vld_reg[i-1];
            mvld_reg[0] <= vld_reg[NS-1];
            for (int i = 1; i < NM; i++) mvld_reg[i] <= mvld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NS; i++) stg_reg[i] <= stg_next[i];
        end
    end

    // rotation maths
    logic signed [31:0] v1_reg [3];
    logic signed [31:0] u1_reg [3], u2_reg [3], u3_reg [3], u4_reg [3], u5_reg [3];
    logic signed [33:0] cs1_reg, sn1_reg, cs2_reg, sn2_reg, sn3_reg;
    logic               z1_reg, z2_reg, z3_reg, z4_reg, z5_reg, z6_reg;
    logic signed [63:0] pvu_reg [3][3];
    logic signed [65:0] pvc_reg [3];
    logic signed [35:0] d_reg, cr_reg [3];
    logic signed [35:0] tv3_reg [3], tv4_reg [3], tv5_reg [3], tv6_reg [3];
    logic signed [34:0] om_reg;
    logic signed [70:0] wp_reg;
    logic signed [69:0] pcs_reg [3];
    logic signed [40:0] wr_reg;
    logic signed [39:0] ts5_reg [3], ts6_reg [3];
    logic signed [72:0] pu_reg [3];
    logic [95:0]        rot_reg;
    logic [1:0]         flags_reg;
    logic signed [79:0] tmp;
    logic signed [44:0] rsum [3];
    logic [95:0]        rot_next;
    logic               clip_next;

    assign out_data  = rot_reg;
    assign out_flags = flags_reg;

    always_comb begin
        rot_next  = '0;
        clip_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            tmp     = aavr_pkg::rnd30(80'(pu_reg[k]));
            rsum[k] = 45'(tv6_reg[k]) + 45'($signed(tmp[42:0])) + 45'(ts6_reg[k]);
            if (rsum[k] > 45'sd2147483647) begin
                rot_next[32*k +: 32] = 32'h7FFFFFFF;
                clip_next            = 1'b1;
            end else if (rsum[k] < -45'sd2147483648) begin
                rot_next[32*k +: 32] = 32'h80000000;
                clip_next            = 1'b1;
            end else begin
                rot_next[32*k +: 32] = rsum[k][31:0];
            end
        end
        if (z6_reg) begin
            rot_next  = '0;
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [79:0] t80;
        if (ce) begin
            // unit axis and signed sine and cosine
            for (int k = 0; k < 3; k++) begin
                v1_reg[k] <= $signed(stg_reg[NS-1].v[k]);
                u1_reg[k] <= stg_reg[NS-1].neg[k] ? -$signed({1'b0, stg_reg[NS-1].q[k]})
                                                  :  $signed({1'b0, stg_reg[NS-1].q[k]});
            end
            cs1_reg <= stg_reg[NS-1].flip ? -$signed(stg_reg[NS-1].cx) : $signed(stg_reg[NS-1].cx);
            sn1_reg <= stg_reg[NS-1].flip ? -$signed(stg_reg[NS-1].cy) : $signed(stg_reg[NS-1].cy);
            z1_reg  <= stg_reg[NS-1].zero;
            // products of vector with axis and cosine
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) pvu_reg[k][l] <= v1_reg[k] * u1_reg[l];
                pvc_reg[k] <= v1_reg[k] * cs1_reg;
                u2_reg[k]  <= u1_reg[k];
            end
            cs2_reg <= cs1_reg;
            sn2_reg <= sn1_reg;
            z2_reg  <= z1_reg;
            // dot, cross and cosine terms
            t80     = aavr_pkg::rnd30(80'(pvu_reg[0][0]) + 80'(pvu_reg[1][1]) + 80'(pvu_reg[2][2]));
            d_reg   <= t80[35:0];
            t80     = aavr_pkg::rnd30(80'(pvu_reg[1][2]) - 80'(pvu_reg[2][1]));
            cr_reg[0] <= t80[35:0];
            t80     = aavr_pkg::rnd30(80'(pvu_reg[2][0]) - 80'(pvu_reg[0][2]));
            cr_reg[1] <= t80[35:0];
            t80     = aavr_pkg::rnd30(80'(pvu_reg[0][1]) - 80'(pvu_reg[1][0]));
            cr_reg[2] <= t80[35:0];
            for (int k = 0; k < 3; k++) begin
                t80        = aavr_pkg::rnd30(80'(pvc_reg[k]));
                tv3_reg[k] <= t80[35:0];
                u3_reg[k]  <= u2_reg[k];
            end
            om_reg  <= 35'sd1073741824 - 35'(cs2_reg);
            sn3_reg <= sn2_reg;
            z3_reg  <= z2_reg;
            // scale of the axis term and cross times sine
            wp_reg <= d_reg * om_reg;
            for (int k = 0; k < 3; k++) begin
                pcs_reg[k] <= cr_reg[k] * sn3_reg;
                tv4_reg[k] <= tv3_reg[k];
                u4_reg[k]  <= u3_reg[k];
            end
            z4_reg <= z3_reg;
            // rounding of those products
            t80    = aavr_pkg::rnd30(80'(wp_reg));
            wr_reg <= t80[40:0];
            for (int k = 0; k < 3; k++) begin
                t80        = aavr_pkg::rnd30(80'(pcs_reg[k]));
                ts5_reg[k] <= t80[39:0];
                tv5_reg[k] <= tv4_reg[k];
                u5_reg[k]  <= u4_reg[k];
            end
            z5_reg <= z4_reg;
            // axis term
            for (int k = 0; k < 3; k++) begin
                pu_reg[k]  <= u5_reg[k] * wr_reg;
                tv6_reg[k] <= tv5_reg[k];
                ts6_reg[k] <= ts5_reg[k];
            end
            z6_reg <= z5_reg;
            // final sum and saturation
            rot_reg   <= rot_next;
            flags_reg <= {clip_next, z6_reg};
        end
    end
endmodule

>>> rtl/axis_angle_vector_rotate_core.sv
// Axis-angle vector rotation core: one request per cycle in, one result per request out,
// in order. Each request carries a Q16.16 vector, a Q16.16 axis of any length and a
// 16-bit turn angle; the result is the vector rotated about the normalised axis,
// saturated to 32 bits, with flags for a zero axis and for clipping. Throughput is one
// item per cycle while neither side stalls. The back end holds the 32-step square root
// and 31-step axis divider pipelines. A four-entry queue separates the front end from
// the back end, and both sides may stall freely.
// depends on aavr_pkg, aavr_front, aavr_fifo, aavr_back
module axis_angle_vector_rotate_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // rot_x, rot_y, rot_z
    output logic [1:0]   m_tuser    // axis_zero, clipped
);
    logic          push, q_full, pop;
    aavr_pkg::fr_t push_item;
    aavr_pkg::fq_t head;

    aavr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    aavr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    aavr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_flags (m_tuser)
    );
endmodule

>>> rtl/aavr_checker.sv
// port-level checker for the axis-angle rotation core, bound to the top level
// depends on axis_angle_vector_rotate_core_macros.svh
`include "axis_angle_vector_rotate_core_macros.svh"
module aavr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [207:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    // a stalled result holds
    `AAVR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // zero axis gives zero vector and no clipping
    `AAVR_ASSERT_IMPL(a_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 96'd0 && !m_tuser[1])
    // clipping shows a rail value on some coordinate
    `AAVR_ASSERT_IMPL(a_clip, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata[31:0] == 32'h7FFFFFFF || m_tdata[31:0] == 32'h80000000 || m_tdata[63:32] == 32'h7FFFFFFF || m_tdata[63:32] == 32'h80000000 || m_tdata[95:64] == 32'h7FFFFFFF || m_tdata[95:64] == 32'h80000000)
    // nothing comes out straight after reset
    `AAVR_ASSERT_NEXT_NR(a_rst, aclk, !aresetn, !m_tvalid)
endmodule

bind axis_angle_vector_rotate_core aavr_checker u_aavr_checker (.*);

>>> tb/sv/tb.sv
// self-checking testbench for axis_angle_vector_rotate_core: directed table then random requests
// depends on aavr_pkg and the core; carries its own fixed-point rodrigues rotation predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEM_COUNT = 1900;
    localparam int  STALL_MAX  = 15;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  DRAIN_WAIT = 200;
    localparam logic signed [127:0] GAIN = 128'sd652032874;
    localparam logic signed [127:0] UNIT = 128'sd1073741824;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;

    localparam logic [31:0] ARC_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [2:0][31:0] vec;
        logic [2:0][31:0] axis;
        logic [15:0]      turn;
    } rot_req_t;

    typedef struct packed {
        logic [2:0][31:0] rot;
        logic             axis_zero;
        logic             clipped;
    } rot_res_t;

    typedef struct {
        rot_req_t req;
        logic     typed;
        rot_res_t res;
    } table_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // rot_x, rot_y, rot_z
    logic [1:0]   m_tuser;   // axis_zero, clipped

    rot_res_t   pending_rot[$];
    table_row_t stim_table[$];
    int         err_count;
    int         idle_cycles;
    bit         stim_done;

    axis_angle_vector_rotate_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic signed [127:0] round_q30(input logic signed [127:0] p);
        return (p + 128'sd536870912) >>> 30;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic rot_res_t rotate_about_axis(input rot_req_t q);
        logic signed [127:0] v[3], u[3], c[3];
        logic signed [127:0] cs, sn, x, y, z, xs, ys, d, w, r;
        logic [63:0]         mag, sq_sum, len;
        logic [31:0]         phase;
        logic                flip;
        rot_res_t            res;
        sq_sum = 0;
        for (int k = 0; k < 3; k++) begin
            v[k] = 128'(signed'(q.vec[k]));
            u[k] = 128'(signed'(q.axis[k]));
            mag = (u[k] < 0) ? 64'(-u[k]) : 64'(u[k]);
            sq_sum = sq_sum + mag * mag;
        end
        len = root_floor(sq_sum);
        res = '0;
        if (len == 0) begin
            res.axis_zero = 1'b1;
            return res;
        end
        for (int k = 0; k < 3; k++) begin
            mag = (u[k] < 0) ? 64'(-u[k]) : 64'(u[k]);
            mag = ((mag << 30) + (len >> 1)) / len;
            u[k] = (u[k] < 0) ? -128'(mag) : 128'(mag);
        end
        // fold the angle into the first and fourth quadrants
        phase = {q.turn, 16'h0};
        flip = (q.turn[15:14] == 2'd1) || (q.turn[15:14] == 2'd2);
        if (flip) phase = phase - 32'h8000_0000;
        z = 128'(signed'(phase));
        x = GAIN;
        y = 0;
        for (int i = 0; i < aavr_pkg::NSTEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - 128'(ARC_TURNS[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + 128'(ARC_TURNS[i]);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
        d = round_q30(v[0] * u[0] + v[1] * u[1] + v[2] * u[2]);
        w = round_q30(d * (UNIT - cs));
        c[0] = round_q30(v[1] * u[2] - v[2] * u[1]);
        c[1] = round_q30(v[2] * u[0] - v[0] * u[2]);
        c[2] = round_q30(v[0] * u[1] - v[1] * u[0]);
        for (int k = 0; k < 3; k++) begin
            r = round_q30(v[k] * cs) + round_q30(u[k] * w) + round_q30(c[k] * sn);
            if (r > 128'sd2147483647) begin
                r = 128'sd2147483647;
                res.clipped = 1'b1;
            end else if (r < -128'sd2147483648) begin
                r = -128'sd2147483648;
                res.clipped = 1'b1;
            end
            res.rot[k] = r[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("t=%0t %s: got %h want %h", $realtime, field, got, want);
        err_count++;
    endtask

    task automatic add_row(input logic [31:0] vx, vy, vz, ax, ay, az, input logic [15:0] t,
                           input logic typed, input rot_res_t res);
        table_row_t row;
        row.req.vec  = {vz, vy, vx};
        row.req.axis = {az, ay, ax};
        row.req.turn = t;
        row.typed    = typed;
        row.res      = res;
        stim_table   = {stim_table, row};
    endtask

    function automatic logic [31:0] pick_coord(input int kind);
        case (kind)
            0, 1, 2: return $urandom;
            3, 4, 5, 6: return 32'(signed'(20'($urandom)));
            7: return 32'(signed'(3'($urandom)));
            default: begin
                case ($urandom_range(0, 4))
                    0: return SMIN;
                    1: return SMAX;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h1;
                endcase
            end
        endcase
    endfunction

    // sender: one request per row, random gap before each, bursts with no gaps
    task automatic send_request(input rot_req_t q, input rot_res_t want, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q.turn, q.axis, q.vec};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_rot = {pending_rot, want};
    endtask

    initial begin
        rot_req_t q;
        rot_res_t zero_res;
        int       kind;
        int       gap;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        aresetn   = 1'b0;
        err_count = 0;
        stim_done = 1'b0;
        zero_res  = '0;
        zero_res.axis_zero = 1'b1;

        // zero axis rows are known outright; the rest go through the predictor
        add_row(SMAX, SMAX, SMAX, 0, 0, 0, 16'h0000, 1'b1, zero_res);
        add_row(SMIN, SMIN, SMIN, 0, 0, 0, 16'hFFFF, 1'b1, zero_res);
        add_row(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 0, 0, 0, 16'h4000, 1'b1, zero_res);
        add_row(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 16'h0000, 1'b0, '0);
        add_row(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 16'h4000, 1'b0, '0);
        add_row(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 16'h8000, 1'b0, '0);
        add_row(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 16'hC000, 1'b0, '0);
        add_row(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 16'hFFFF, 1'b0, '0);
        add_row(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1, 0, 0, 16'h2000, 1'b0, '0);
        add_row(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 16'h0000, 1'b0, '0);
        add_row(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 16'h4000, 1'b0, '0);
        add_row(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 16'h8000, 1'b0, '0);
        add_row(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 16'hC000, 1'b0, '0);
        add_row(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 16'h2000, 1'b0, '0);
        add_row(SMAX, SMAX, 0, 0, 0, 32'h0001_0000, 16'h2000, 1'b0, '0);
        add_row(SMIN, SMIN, 0, 0, 0, SMIN, 16'h6000, 1'b0, '0);
        add_row(SMAX, 0, SMIN, SMIN, 1, SMAX, 16'hA000, 1'b0, '0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                16'h7FFF, 1'b0, '0);
        add_row(1, 1, 1, 1, 1, 1, 16'h8001, 1'b0, '0);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333,
                32'hCCCC_CCCC, 16'h5A5A, 1'b0, '0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < stim_table.size(); n++) begin
            gap = $urandom_range(0, STALL_MAX);
            send_request(stim_table[n].req,
                         stim_table[n].typed ? stim_table[n].res
                                             : rotate_about_axis(stim_table[n].req), gap);
        end

        for (int n = 0; n < ITEM_COUNT; n++) begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++) begin
                q.vec[k]  = pick_coord(kind == 9 ? 9 : (kind == 0 ? 0 : kind - 1));
                q.axis[k] = (kind == 0) ? 32'h0 : pick_coord(kind - 1);
            end
            q.turn = $urandom;
            gap = ((n / 150) % 3 == 1) ? 0 : $urandom_range(0, STALL_MAX);
            send_request(q, rotate_about_axis(q), gap);
        end
        s_tvalid  <= 1'b0;
        stim_done = 1'b1;

        while (pending_rot.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("axis_angle_vector_rotate_core: match");
        end else begin
            $display("axis_angle_vector_rotate_core: mismatch");
        end
        $finish;
    end

    // receiver: stall a random number of cycles before taking each result
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = (($urandom_range(0, 3) == 0) || stim_done) ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        rot_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rot.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_rot.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (m_tdata[32*k +: 32] !== want.rot[k])
                        report_mismatch($sformatf("rot[%0d]", k), m_tdata[32*k +: 32],
                                        want.rot[k]);
                end
                if (m_tuser[0] !== want.axis_zero)
                    report_mismatch("axis_zero", 32'(m_tuser[0]), 32'(want.axis_zero));
                if (m_tuser[1] !== want.clipped)
                    report_mismatch("clipped", 32'(m_tuser[1]), 32'(want.clipped));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("axis_angle_vector_rotate_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
